@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the UUID parser; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/uhp_pkg.sv @@
// ---------------------------------------------------------------------------
// uhp_pkg
// Shared types and character constants for the UUID hex string parser.
// ---------------------------------------------------------------------------
`default_nettype none

package uhp_pkg;

  // ASCII codes the decoder looks for
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  // Limits of a well-formed string
  localparam int unsigned NIBBLE_BITS   = 4;
  localparam int unsigned NIBBLES_TOTAL = 32;
  localparam int unsigned VALUE_BITS    = NIBBLE_BITS * NIBBLES_TOTAL;
  localparam logic [5:0]  DIGITS_FULL   = 6'd32;
  localparam logic [2:0]  DASH_LIMIT    = 3'd4;

  // Classification of one character
  typedef struct packed {
    logic       is_hex;
    logic       is_dash;
    logic [3:0] nibble;
  } uhp_char_t;

  // One parse result; value holds byte 0 in its top bits
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  ok;
  } uhp_result_t;

endpackage

`default_nettype wire

@@ sv/uhp_decode.sv @@
// ---------------------------------------------------------------------------
// uhp_decode
// Classifies one ASCII byte as dash, hex digit (with its value) or other.
// ---------------------------------------------------------------------------
`default_nettype none

module uhp_decode
  import uhp_pkg::*;
(
  input  wire logic [7:0] char_code,
  output uhp_char_t       cls
);

  logic is_digit;
  logic is_lower;
  logic is_upper;

  // Range checks for the three digit groups
  assign is_digit = (char_code >= CHAR_ZERO)    && (char_code <= CHAR_NINE);
  assign is_lower = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
  assign is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);

  // Pick the nibble value from whichever group matched
  always_comb begin
    cls.is_dash = (char_code == CHAR_DASH);
    cls.is_hex  = is_digit || is_lower || is_upper;
    if (is_digit) begin
      cls.nibble = 4'(char_code - CHAR_ZERO);
    end else if (is_lower) begin
      cls.nibble = 4'(char_code - CHAR_LOWER_A) + 4'd10;
    end else if (is_upper) begin
      cls.nibble = 4'(char_code - CHAR_UPPER_A) + 4'd10;
    end else begin
      cls.nibble = 4'd0;
    end
  end

endmodule

`default_nettype wire

@@ sv/uhp_accum.sv @@
// ---------------------------------------------------------------------------
// uhp_accum
// Holds the value under assembly, digit and dash counts and the fail flag;
// applies one classified character per step and clears after the last one.
// ---------------------------------------------------------------------------
`default_nettype none

module uhp_accum
  import uhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire logic      is_final,
  input  wire uhp_char_t cls,
  output uhp_result_t    result
);

  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] value_next;
  logic [5:0]            digit_count;
  logic [5:0]            digit_count_next;
  logic [2:0]            dash_count;
  logic [2:0]            dash_count_next;
  logic                  failed;
  logic                  failed_next;
  logic                  take_digit;

  // Apply one character to the running state
  always_comb begin
    digit_count_next = digit_count;
    dash_count_next  = dash_count;
    failed_next      = failed;
    take_digit       = 1'b0;
    if (!failed) begin
      if (digit_count >= DIGITS_FULL) begin
        failed_next = 1'b1;
      end else if (cls.is_dash) begin
        dash_count_next = dash_count + 3'd1;
        if (dash_count_next > DASH_LIMIT) begin
          failed_next = 1'b1;
        end
      end else if (!cls.is_hex) begin
        failed_next = 1'b1;
      end else begin
        take_digit       = 1'b1;
        digit_count_next = digit_count + 6'd1;
      end
    end
  end

  // Insert the nibble at its slot, byte 0 high nibble first
  for (genvar i = 0; i < NIBBLES_TOTAL; i++) begin : g_slot
    localparam int unsigned HI = VALUE_BITS - 1 - NIBBLE_BITS * i;
    assign value_next[HI -: NIBBLE_BITS] =
      (take_digit && (digit_count[4:0] == 5'(i))) ? cls.nibble : value[HI -: NIBBLE_BITS];
  end

  // Result as seen after this character
  assign result.value = value_next;
  assign result.ok    = !failed_next && (digit_count_next == DIGITS_FULL);

  // Advance state; clear after the last character of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      value       <= '0;
      digit_count <= '0;
      dash_count  <= '0;
      failed      <= 1'b0;
    end else if (step) begin
      if (is_final) begin
        value       <= '0;
        digit_count <= '0;
        dash_count  <= '0;
        failed      <= 1'b0;
      end else begin
        value       <= value_next;
        digit_count <= digit_count_next;
        dash_count  <= dash_count_next;
        failed      <= failed_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/uuid_hex_string_parser.sv @@
// ---------------------------------------------------------------------------
// uuid_hex_string_parser
// Parses a 128-bit UUID from a stream of ASCII characters, one per beat.
//
//   Channel   Dir  Beat content
//   s_*       in   tdata = char_code[7:0], tlast = is_final
//   m_*       out  tdata = uuid_upper, uuid_lower; tuser = parse_ok
//
// One character per cycle sustained while no last character waits on a
// stalled output; a beat is held in the input register, and a last
// character loads its result into the output register as it leaves it,
// from where the result is offered on m_*.
// Reset clears the string state and both valid flags; no clearing pass.
// Only a last-character beat waits on a stalled output; other characters
// keep flowing while a result is held.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module uuid_hex_string_parser
  import uhp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] char_code
  input  wire logic         s_tlast,   // is_final
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // [63:0] uuid_upper, [127:64] uuid_lower
  output logic              m_tuser    // [0] parse_ok
);

  logic        in_vld;
  logic [7:0]  in_char;
  logic        in_final;
  logic        advance;
  uhp_char_t   cls;
  uhp_result_t result;
  logic [VALUE_BITS-1:0] out_value;
  logic        out_ok;

  // Move the held beat on unless it is a last character facing a full output
  assign advance  = in_vld && (!in_final || !m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char  <= s_tdata;
      in_final <= s_tlast;
    end
  end

  uhp_decode u_decode (
    .char_code (in_char),
    .cls       (cls)
  );

  uhp_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .is_final (in_final),
    .cls      (cls),
    .result   (result)
  );

  // Output register: load on a last character, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_final) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_final) begin
      out_value <= result.value;
      out_ok    <= result.ok;
    end
  end

  assign m_tdata = {out_value[VALUE_BITS/2-1:0], out_value[VALUE_BITS-1:VALUE_BITS/2]};
  assign m_tuser = out_ok;

  // A last character always produces a result next cycle
  `ASSERT_NEXT(a_final_emits, clk, rst, advance && in_final, m_tvalid)
  // A result only appears after a last character moved on
  `ASSERT_IMPLIES(a_emit_source, clk, rst, $rose(m_tvalid), $past(advance && in_final))
  // Input stalls only for a last character behind a stalled result
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, !s_tready,
                  in_vld && in_final && m_tvalid && !m_tready)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for uuid_hex_string_parser. Feeds character strings
// (short directed cases, then random strings, half of them well-formed UUIDs
// and half broken or noisy strings), predicts each parsed result, and
// checks every output beat against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import uhp_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 950;
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 1200;

  typedef struct {
    logic [7:0] code;
    logic       last;
    logic       drain;  // hold this beat until all results are back
  } char_beat_t;

  typedef struct {
    logic [63:0] upper;
    logic [63:0] lower;
    logic        ok;
  } uuid_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;   // [7:0] char_code
  logic         s_tlast = 1'b0;    // is_final
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;           // [63:0] uuid_upper, [127:64] uuid_lower
  logic         m_tuser;           // [0] parse_ok

  char_beat_t   char_q[$];
  uuid_result_t uuid_expected_q[$];
  int           errors = 0;
  int           cycle_count = 0;

  // Parser state mirrored by the predictor
  logic [63:0]  acc_words[2] = '{64'd0, 64'd0};
  logic [5:0]   acc_digits = '0;
  logic [2:0]   acc_dashes = '0;
  logic         acc_failed = 1'b0;

  uuid_hex_string_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Classify one character as hex digit, dash or neither
  function automatic uhp_char_t classify(input logic [7:0] c);
    uhp_char_t r;
    r = '0;
    r.is_dash = (c == CHAR_DASH);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r.is_hex = 1'b1;
      r.nibble = 4'(c - CHAR_ZERO);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      r.is_hex = 1'b1;
      r.nibble = 4'(c - CHAR_LOWER_A + 8'd10);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      r.is_hex = 1'b1;
      r.nibble = 4'(c - CHAR_UPPER_A + 8'd10);
    end
    return r;
  endfunction

  // Advance the mirrored parser by one character; queue a result on the last one
  task automatic parse_char(input logic [7:0] c, input logic fin);
    uhp_char_t    cls;
    uuid_result_t res;
    cls = classify(c);
    if (!acc_failed) begin
      if (acc_digits >= DIGITS_FULL) begin
        acc_failed = 1'b1;
      end else if (cls.is_dash) begin
        acc_dashes = acc_dashes + 3'd1;
        if (acc_dashes > DASH_LIMIT) acc_failed = 1'b1;
      end else if (!cls.is_hex) begin
        acc_failed = 1'b1;
      end else begin
        acc_words[acc_digits[4]][63 - 4 * acc_digits[3:0] -: 4] = cls.nibble;
        acc_digits = acc_digits + 6'd1;
      end
    end
    if (fin) begin
      res.upper = acc_words[0];
      res.lower = acc_words[1];
      res.ok    = !acc_failed && (acc_digits == DIGITS_FULL);
      uuid_expected_q.push_back(res);
      acc_words  = '{64'd0, 64'd0};
      acc_digits = '0;
      acc_dashes = '0;
      acc_failed = 1'b0;
    end
  endtask

  // Random idling, suppressed during the calm window
  function automatic bit idle_now();
    if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) return 1'b0;
    return $urandom_range(99) < 33;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int nib;
    nib = $urandom_range(15);
    if (nib < 10) return CHAR_ZERO + 8'(nib);
    if ($urandom_range(1) != 0) return CHAR_UPPER_A + 8'(nib - 10);
    return CHAR_LOWER_A + 8'(nib - 10);
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    uhp_char_t  cls;
    do begin
      c   = 8'($urandom_range(255));
      cls = classify(c);
    end while (cls.is_hex || cls.is_dash);
    return c;
  endfunction

  // Build one string and queue its beats; the last beat carries tlast
  task automatic add_string(input int n_digits, input bit canon, input int n_dashes,
                            input int n_bad, input int n_extra, input bit drain);
    logic [7:0] s[$];
    int         pick;
    for (int i = 0; i < n_digits; i++) begin
      if (canon && (i == 8 || i == 12 || i == 16 || i == 20)) s.push_back(CHAR_DASH);
      s.push_back(rand_hex_char());
    end
    // dashes never land after the last character here
    repeat (n_dashes) s.insert($urandom_range(s.size() > 0 ? s.size() - 1 : 0), CHAR_DASH);
    repeat (n_bad) s.insert($urandom_range(s.size()), rand_bad_char());
    repeat (n_extra) begin
      pick = $urandom_range(2);
      if (pick == 0) s.push_back(rand_hex_char());
      else if (pick == 1) s.push_back(CHAR_DASH);
      else s.push_back(8'($urandom_range(255)));
    end
    if (s.size() == 0) s.push_back(rand_hex_char());
    for (int i = 0; i < s.size(); i++)
      char_q.push_back('{code: s[i], last: (i == s.size() - 1), drain: (drain && i == 0)});
  endtask

  task automatic add_single(input logic [7:0] c);
    char_q.push_back('{code: c, last: 1'b1, drain: 1'b0});
  endtask

  // Stimulus, then wait for all results and report
  initial begin
    int kind;
    int strings;
    int n_dig;
    // single-character strings: field extremes and hex range edges
    add_single(8'h00);
    add_single(8'hFF);
    add_single(CHAR_DASH);
    add_single(CHAR_ZERO);
    add_single(CHAR_NINE);
    add_single(CHAR_LOWER_A);
    add_single(CHAR_LOWER_F);
    add_single(CHAR_UPPER_A);
    add_single(CHAR_UPPER_F);
    add_single(CHAR_ZERO - 8'd1);
    add_single(CHAR_NINE + 8'd1);
    add_single(CHAR_LOWER_A - 8'd1);
    add_single(CHAR_LOWER_F + 8'd1);
    add_single(CHAR_UPPER_A - 8'd1);
    add_single(CHAR_UPPER_F + 8'd1);
    // fifth dash fails the string
    add_string(0, 1'b0, 5, 0, 0, 1'b0);
    // canonical string held back until every earlier result is in
    add_string(32, 1'b1, 0, 0, 0, 1'b1);

    strings = 0;
    while (char_q.size() < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      strings++;
      if (kind < 25) begin
        // canonical 8-4-4-4-12 layout
        add_string(32, 1'b1, 0, 0, 0, strings % 25 == 5);
      end else if (kind < 50) begin
        // valid digits, dashes anywhere
        add_string(32, 1'b0, $urandom_range(4), 0, 0, strings % 25 == 5);
      end else if (kind < 62) begin
        // characters past the 32nd digit
        add_string(32, $urandom_range(1), 0, 0, $urandom_range(3, 1), 1'b0);
      end else if (kind < 72) begin
        // too many dashes
        add_string(32, 1'b0, $urandom_range(7, 5), 0, 0, 1'b0);
      end else if (kind < 82) begin
        // non-hex character somewhere
        add_string(32, 1'b0, $urandom_range(4), $urandom_range(2, 1), 0, 1'b0);
      end else if (kind < 92) begin
        // short string
        n_dig = $urandom_range(31, 1);
        add_string(n_dig, 1'b0, $urandom_range(4), 0, 0, 1'b0);
      end else begin
        // noise bytes only
        add_string(0, 1'b0, 0, $urandom_range(8, 1), 0, 1'b0);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (char_q.size() != 0 || s_tvalid) @(negedge clk);
    while (uuid_expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Drive character beats; predict on each accepted beat
  always @(posedge clk) begin : drive
    char_beat_t beat;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) parse_char(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (char_q.size() != 0 && !(char_q[0].drain && uuid_expected_q.size() != 0)
            && !idle_now()) begin
          beat = char_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= beat.code;
          s_tlast  <= beat.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check result beats against the oldest prediction; stall at random
  always @(posedge clk) begin : watch
    uuid_result_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (uuid_expected_q.size() == 0) begin
          $error("result beat with none expected: tdata %h tuser %b", m_tdata, m_tuser);
          errors++;
        end else begin
          exp_res = uuid_expected_q.pop_front();
          if (m_tdata[63:0] !== exp_res.upper) begin
            $error("uuid_upper: expected %h, actual %h", exp_res.upper, m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[127:64] !== exp_res.lower) begin
            $error("uuid_lower: expected %h, actual %h", exp_res.lower, m_tdata[127:64]);
            errors++;
          end
          if (m_tuser !== exp_res.ok) begin
            $error("parse_ok: expected %b, actual %b", exp_res.ok, m_tuser);
            errors++;
          end
        end
      end
      m_tready <= !idle_now();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

`default_nettype wire
